/* rtl/mcsg_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint circle span generator package
// Shared widths, word layouts, codes and the step record passed from the
// front end to the span back end.
// ---------------------------------------------------------------------------
package mcsg_pkg;

  // Coordinate and radius sizes of the circle datapath.
  localparam int COORD_BITS  = 13;
  localparam int RADIUS_BITS = 11;

  // Step counters hold up to radius + 1; the decision term stays within
  // a few multiples of the radius.
  localparam int STEP_W  = RADIUS_BITS + 1;
  localparam int DEC_W   = RADIUS_BITS + 5;

  localparam int SCR_W   = 12;
  localparam int ROW_W   = 14;
  localparam int COLOR_W = 24;
  localparam int PIXEL_W = 32;

  // Span arithmetic is wide enough for centre plus or minus a step and for
  // comparison against the screen size.
  localparam int SUM_BASE = ((COORD_BITS > STEP_W + 1) ? COORD_BITS : STEP_W + 1) + 1;
  localparam int SUM_W    = (SUM_BASE > ROW_W) ? SUM_BASE : ROW_W;

  // Input word layout, lowest bit first.
  localparam int IN_CX_LSB    = 0;
  localparam int IN_CY_LSB    = IN_CX_LSB + COORD_BITS;
  localparam int IN_R_LSB     = IN_CY_LSB + COORD_BITS;
  localparam int IN_FILL_BIT  = IN_R_LSB + RADIUS_BITS;
  localparam int IN_RED_LSB   = IN_FILL_BIT + 1;
  localparam int IN_GREEN_LSB = IN_RED_LSB + 8;
  localparam int IN_BLUE_LSB  = IN_GREEN_LSB + 8;
  localparam int IN_USED      = IN_BLUE_LSB + 8;
  localparam int IN_TDATA_W   = ((IN_USED + 7) / 8) * 8;

  // Output word layout, lowest bit first.
  localparam int OUT_ROW_LSB = 0;
  localparam int OUT_CF_LSB  = OUT_ROW_LSB + ROW_W;
  localparam int OUT_CL_LSB  = OUT_CF_LSB + SCR_W;
  localparam int OUT_VIS_BIT = OUT_CL_LSB + SCR_W;
  localparam int OUT_PIX_LSB = OUT_VIS_BIT + 1;
  localparam int OUT_USED    = OUT_PIX_LSB + PIXEL_W;
  localparam int OUT_TDATA_W = ((OUT_USED + 7) / 8) * 8;

  // Command and register codes.
  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  localparam logic [SCR_W-1:0] SCREEN_W_RESET = 12'd800;
  localparam logic [SCR_W-1:0] SCREEN_H_RESET = 12'd600;
  localparam logic [7:0]       ALPHA_OPAQUE   = 8'hFF;

  // Decision term constants of the midpoint recurrence.
  localparam int DEC_INIT = 3;
  localparam int DEC_DIAG = 10;
  localparam int DEC_AXIS = 6;

  // Spans per step and the span index width.
  localparam int SPAN_IDX_W = 3;
  localparam logic [SPAN_IDX_W-1:0] LAST_SPAN_OUTLINE = 3'd7;
  localparam logic [SPAN_IDX_W-1:0] LAST_SPAN_FILL    = 3'd3;

  // One queued step: either a finished marker or a set of spans.
  typedef struct packed {
    logic                         finished;
    logic                         fill;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [STEP_W-1:0]            x;
    logic [STEP_W-1:0]            y;
    logic [COLOR_W-1:0]           color;
  } job_t;

endpackage

/* rtl/mcsg_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint circle front end
// Accepts command words, holds the circle state and runs one midpoint step
// per advance, handing each step to the span queue.
// ---------------------------------------------------------------------------
module mcsg_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [mcsg_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                              s_axis_tuser_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output mcsg_pkg::job_t                    q_job_o
);
  import mcsg_pkg::*;

  logic signed [COORD_BITS-1:0] ctr_x_q, ctr_y_q;
  logic [STEP_W-1:0]            step_x_q, step_y_q;
  logic [DEC_W-1:0]             dec_q;
  logic [COLOR_W-1:0]           color_q;
  logic                         fill_q, active_q;

  logic                         accept, is_start, done;
  logic                         diag;
  logic [STEP_W-1:0]            x_nx, y_nx;
  logic [DEC_W-1:0]             dec_add, dec_init;
  logic [RADIUS_BITS-1:0]       radius;

  assign s_axis_tready_o = !q_full_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_start = (s_axis_tuser_i == CMD_START);
  assign done     = !active_q || (step_y_q < step_x_q);
  assign radius   = s_axis_tdata_i[IN_R_LSB +: RADIUS_BITS];
  assign dec_init = DEC_W'(DEC_INIT) - (DEC_W'(radius) << 1);

  // Next step of the recurrence. A zero radius would take y below zero on
  // its only step; holding it at zero still ends the circle, since x is
  // then one.
  always_comb begin
    diag = !dec_q[DEC_W-1] && (dec_q != '0);
    x_nx = step_x_q + STEP_W'(1);
    y_nx = step_y_q;
    if (diag) begin
      y_nx = (step_y_q == '0) ? '0 : step_y_q - STEP_W'(1);
      dec_add = ((DEC_W'(x_nx) - DEC_W'(y_nx)) << 2) + DEC_W'(DEC_DIAG);
    end else begin
      dec_add = (DEC_W'(x_nx) << 2) + DEC_W'(DEC_AXIS);
    end
  end

  // Step record for the back end, taken from the state before the update.
  always_comb begin
    q_push_o       = accept && !is_start;
    q_job_o.finished = done;
    q_job_o.fill   = fill_q;
    q_job_o.cx     = ctr_x_q;
    q_job_o.cy     = ctr_y_q;
    q_job_o.x      = step_x_q;
    q_job_o.y      = step_y_q;
    q_job_o.color  = color_q;
  end

  // Circle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
      step_x_q <= '0;
      step_y_q <= '0;
      dec_q    <= '0;
      color_q  <= '0;
      fill_q   <= 1'b0;
      active_q <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        ctr_x_q  <= s_axis_tdata_i[IN_CX_LSB +: COORD_BITS];
        ctr_y_q  <= s_axis_tdata_i[IN_CY_LSB +: COORD_BITS];
        step_x_q <= '0;
        step_y_q <= STEP_W'(radius);
        dec_q    <= dec_init;
        fill_q   <= s_axis_tdata_i[IN_FILL_BIT];
        color_q  <= {s_axis_tdata_i[IN_BLUE_LSB +: 8], s_axis_tdata_i[IN_GREEN_LSB +: 8],
                     s_axis_tdata_i[IN_RED_LSB +: 8]};
        active_q <= 1'b1;
      end else if (done) begin
        active_q <= 1'b0;
      end else begin
        step_x_q <= x_nx;
        step_y_q <= y_nx;
        dec_q    <= dec_q + dec_add;
      end
    end
  end

endmodule

/* rtl/mcsg_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint circle step queue
// Small first-in first-out buffer of step records between front and back.
// ---------------------------------------------------------------------------
module mcsg_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcsg_pkg::job_t data_i,
  input  logic           pop_i,
  output mcsg_pkg::job_t data_o,
  output logic           not_empty_o,
  output logic           full_o
);
  import mcsg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign not_empty_o = (count_q != '0);
  assign full_o      = (count_q == CNT_W'(DEPTH));
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign data_o      = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/mcsg_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint circle span back end
// Walks the spans of the queued step one per cycle when the output is not
// stalled, clips each to the screen and drives the registered output word.
// ---------------------------------------------------------------------------
module mcsg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [mcsg_pkg::SCR_W-1:0]        cfg_data_i,
  input  mcsg_pkg::job_t                    q_job_i,
  input  logic                              q_not_empty_i,
  output logic                              q_pop_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [mcsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tuser_o
);
  import mcsg_pkg::*;

  logic [SCR_W-1:0]      width_q, height_q;
  logic [SPAN_IDX_W-1:0] span_q;
  logic                  out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                  out_last_q, out_fin_q;

  logic                  adv, last_span, swap, row_neg, col_neg;
  logic [STEP_W-1:0]     row_off, col_off;
  logic signed [SUM_W-1:0] cx_s, cy_s, row_off_s, col_off_s;
  logic signed [SUM_W-1:0] row, left, right, wm1, hh, clip_a, clip_b;
  logic                  vis;
  logic [OUT_TDATA_W-1:0] span_word;

  // Screen size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_W_RESET;
      height_q <= SCREEN_H_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv     = q_not_empty_i && (!out_valid_q || m_axis_tready_i);
  assign last_span = q_job_i.fill ? (span_q == LAST_SPAN_FILL)
                                  : (span_q == LAST_SPAN_OUTLINE);
  assign q_pop_o = adv && (q_job_i.finished || last_span);

  // Span geometry. Fill spans run across the row; outline spans are single
  // points, one for each octant.
  always_comb begin
    if (q_job_i.fill) begin
      swap    = span_q[1];
      row_neg = span_q[0];
      col_neg = 1'b0;
    end else begin
      swap    = span_q[2];
      row_neg = span_q[1];
      col_neg = span_q[0];
    end
    row_off   = swap ? q_job_i.x : q_job_i.y;
    col_off   = swap ? q_job_i.y : q_job_i.x;
    cx_s      = SUM_W'(q_job_i.cx);
    cy_s      = SUM_W'(q_job_i.cy);
    row_off_s = SUM_W'(row_off);
    col_off_s = SUM_W'(col_off);
    row       = row_neg ? cy_s - row_off_s : cy_s + row_off_s;
    if (q_job_i.fill) begin
      left  = cx_s - col_off_s;
      right = cx_s + col_off_s;
    end else begin
      left  = col_neg ? cx_s - col_off_s : cx_s + col_off_s;
      right = left;
    end
  end

  // Clipping against the configured screen.
  always_comb begin
    wm1    = SUM_W'(width_q) - SUM_W'(1);
    hh     = SUM_W'(height_q);
    vis    = !row[SUM_W-1] && (row < hh) && (left <= right) && !right[SUM_W-1] &&
             (left <= wm1);
    clip_a = left[SUM_W-1] ? '0 : left;
    clip_b = (right > wm1) ? wm1 : right;
    if (!vis) begin
      clip_a = '0;
      clip_b = '0;
    end
    span_word = '0;
    span_word[OUT_ROW_LSB +: ROW_W]   = row[ROW_W-1:0];
    span_word[OUT_CF_LSB +: SCR_W]    = clip_a[SCR_W-1:0];
    span_word[OUT_CL_LSB +: SCR_W]    = clip_b[SCR_W-1:0];
    span_word[OUT_VIS_BIT]            = vis;
    span_word[OUT_PIX_LSB +: PIXEL_W] = {ALPHA_OPAQUE, q_job_i.color};
  end

  // Span counter and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        span_q      <= q_pop_o ? '0 : span_q + SPAN_IDX_W'(1);
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (q_job_i.finished) begin
        out_data_q <= '0;
        out_last_q <= 1'b1;
        out_fin_q  <= 1'b1;
      end else begin
        out_data_q <= span_word;
        out_last_q <= last_span;
        out_fin_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_fin_q;

endmodule

/* rtl/midpoint_circle_span_generator_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint circle span generator
// Rasterises circles into clipped horizontal spans, one midpoint step per
// advance word.
// ---------------------------------------------------------------------------
// Usage:
//  - Input stream: tuser carries the command (start or advance), tdata the
//    circle parameters, used on start only. A start word loads a circle and
//    gives no output; each advance word gives one step of spans.
//  - Output stream: one span per word; tlast marks the last span of a step
//    and tuser marks the single word answering an advance after the circle
//    has ended (or before any start).
//  - An accepted advance word is written into the queue; its first span is
//    then taken from the queue head into the output register.
//  - An outline step gives eight spans, a filled step four and a finished
//    word one; the span walker of the back end drives one span a cycle into
//    the output register while the receiver does not stall it.
//  - The front end runs ahead through a queue of QUEUE_DEPTH steps.
//  - Reset clears circle state and queue, sets an 800 by 600 screen. Users
//    write screen size via configuration port only when idle; unenforced.
//  - When the receiver stalls the output word holds, the back end stops, the
//    queue fills and then the input ready falls.
// ---------------------------------------------------------------------------
module midpoint_circle_span_generator_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [mcsg_pkg::SCR_W-1:0]        cfg_data_i,
  // Command words
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: center_x, center_y, radius, fill, red, green, blue, zero pad
  input  logic [mcsg_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: cmd
  input  logic                              s_axis_tuser_i,
  // Span words
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: row, col_first, col_last, visible, pixel_word, zero pad
  output logic [mcsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // tlast: last_of_step
  output logic                              m_axis_tlast_o,
  // tuser: finished
  output logic                              m_axis_tuser_o
);
  import mcsg_pkg::*;

  job_t push_job, head_job;
  logic q_push, q_pop, q_full, q_not_empty;

  mcsg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (push_job)
  );

  mcsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .data_i      (push_job),
    .pop_i       (q_pop),
    .data_o      (head_job),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  mcsg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .q_job_i         (head_job),
    .q_not_empty_i   (q_not_empty),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* rtl/mcsg_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint circle span generator checker
// Port-level properties of the span stream, bound to the top level.
// ---------------------------------------------------------------------------
module mcsg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [mcsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                              m_axis_tlast_o,
  input logic                              m_axis_tuser_o
);
  import mcsg_pkg::*;

  logic [SCR_W-1:0] col_first, col_last;
  logic             vis;

  assign col_first = m_axis_tdata_o[OUT_CF_LSB +: SCR_W];
  assign col_last  = m_axis_tdata_o[OUT_CL_LSB +: SCR_W];
  assign vis       = m_axis_tdata_o[OUT_VIS_BIT];

  // No span word is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("span word offered during reset");

  // A finished word closes its step and carries no span.
  a_finished_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("finished word malformed");

  // Invisible spans report no columns.
  a_invisible_cols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !vis |-> (col_first == '0) && (col_last == '0))
    else $error("invisible span with columns");

  // Visible spans are ordered left to right.
  a_visible_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && vis |-> col_first <= col_last)
    else $error("visible span reversed");

  // A stalled word holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
    && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("stalled span word changed");

endmodule

bind midpoint_circle_span_generator_top mcsg_checker u_mcsg_checker (.*);
